/* rtl/ddf_pkg.sv */
// ----------------------------------------------------------------------------
// ddf_pkg
// shared types, constants and register codes for the detection duplicate filter
// ----------------------------------------------------------------------------
package ddf_pkg;

    // store geometry
    localparam int MAX_KEPT   = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_BITS   = $clog2(MAX_KEPT + 1);

    // field widths
    localparam int FRAME_BITS = 16;
    localparam int SCORE_BITS = 16;
    localparam int DUP_BITS   = 9;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // arithmetic widths
    localparam int OV_BITS    = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int INTER_BITS = 2 * OV_BITS;
    localparam int CMP_BITS   = INTER_BITS + 8;

    // stream payload widths, padded to whole bytes
    localparam int ITEM_RAW_BITS = FRAME_BITS + 4 * COORD_BITS + SCORE_BITS;
    localparam int TDATA_BITS    = ((ITEM_RAW_BITS + 7) / 8) * 8;

    // box growth applied on output
    localparam int GROW_EACH = 20;
    localparam int GROW_BOTH = 40;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_THR   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_W   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_H   = 2'd3;

    // register reset values
    localparam logic signed [SCORE_BITS-1:0] SCORE_THR_RST = '0;
    localparam logic [DUP_BITS-1:0]          DUP_THR_RST   = 9'd128;
    localparam logic [COORD_BITS-1:0]        FRAME_W_RST   = COORD_BITS'(1920);
    localparam logic [COORD_BITS-1:0]        FRAME_H_RST   = COORD_BITS'(1080);

    typedef struct packed {
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } box_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

/* rtl/detection_duplicate_filter_core.sv */
// ----------------------------------------------------------------------------
// detection_duplicate_filter_core
// greedy suppression of duplicate detection boxes by overlap over smaller area
// ----------------------------------------------------------------------------
// an accepted request is scanned against the kept-box memory, then emitted through the
//   result register unless it is a duplicate; the input is ready only while idle
// a new item is taken only after the last is emitted or dropped; the scan reads the
//   kept-box memory one entry per cycle through the compare unit
// a box rejected on score leaves the block in idle, still ready for the next item
// reset: kept_count cleared, registers to their defaults, memory not cleared
module detection_duplicate_filter_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // frame_number, box_x, box_y, box_w, box_h, box_score (lowest bit up)
    input  logic [ddf_pkg::TDATA_BITS-1:0]       s_axis_tdata,
    // start_of_frame
    input  logic [0:0]                           s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_frame_number, out_x, out_y, out_w, out_h, out_score (lowest bit up)
    output logic [ddf_pkg::TDATA_BITS-1:0]       m_axis_tdata,
    // store_full
    output logic [0:0]                           m_axis_tuser,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ddf_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [ddf_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import ddf_pkg::*;

    localparam int X_LO     = FRAME_BITS;
    localparam int Y_LO     = X_LO + COORD_BITS;
    localparam int W_LO     = Y_LO + COORD_BITS;
    localparam int H_LO     = W_LO + COORD_BITS;
    localparam int SCORE_LO = H_LO + COORD_BITS;

    // configuration registers
    logic signed [SCORE_BITS-1:0] score_thr_reg;
    logic [DUP_BITS-1:0]          dup_thr_reg;
    logic [COORD_BITS-1:0]        frame_w_reg;
    logic [COORD_BITS-1:0]        frame_h_reg;

    // control state
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   kept_count_reg, kept_count_next;
    logic [CNT_BITS-1:0]   scan_idx_reg, scan_idx_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic                  dup_reg, dup_next;
    logic                  m_valid_reg, m_valid_next;

    // payload
    logic [FRAME_BITS-1:0]        frame_reg;
    logic signed [SCORE_BITS-1:0] score_reg;
    box_t                         box_reg;
    box_t                         rd_box_reg;
    logic [AREA_BITS-1:0]         an_reg;
    logic [AREA_BITS-1:0]         ak_reg;
    logic [INTER_BITS-1:0]        inter_reg;
    logic                         ident_reg;
    logic [TDATA_BITS-1:0]        m_data_reg;
    logic                         m_full_reg;

    // kept-box memory
    box_t kept_mem [MAX_KEPT];

    // decoded input item
    logic                         in_accept;
    logic                         in_sof;
    logic signed [SCORE_BITS-1:0] in_score;
    logic                         score_pass;
    box_t                         in_box;

    // sequencer controls
    logic                         issue;
    logic                         scan_done;
    logic                         out_free;
    logic                         emit_fire;
    logic                         store_ok;

    // overlap unit
    logic [OV_BITS-1:0]           ov_x;
    logic [OV_BITS-1:0]           ov_y;
    logic                         ident;
    logic [AREA_BITS-1:0]         amin;
    logic [CMP_BITS-1:0]          lhs;
    logic [CMP_BITS-1:0]          rhs;
    logic                         hit;

    // emit values
    logic [2*COORD_BITS-1:0]      gx;
    logic [2*COORD_BITS-1:0]      gy;

    // overlap length of [a0, a0+al) and [b0, b0+bl)
    function automatic logic [OV_BITS-1:0] overlap_len(
        input logic [COORD_BITS-1:0] a0,
        input logic [COORD_BITS-1:0] al,
        input logic [COORD_BITS-1:0] b0,
        input logic [COORD_BITS-1:0] bl
    );
        logic [OV_BITS-1:0] lo;
        logic [OV_BITS-1:0] ae;
        logic [OV_BITS-1:0] be;
        logic [OV_BITS-1:0] hi;
        lo = (a0 > b0) ? OV_BITS'(a0) : OV_BITS'(b0);
        ae = OV_BITS'(a0) + OV_BITS'(al);
        be = OV_BITS'(b0) + OV_BITS'(bl);
        hi = (ae < be) ? ae : be;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    // grow by the margin, clamp corner at zero, clip size to the frame
    // returns {size, corner}
    function automatic logic [2*COORD_BITS-1:0] grow_clip(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] len,
        input logic [COORD_BITS-1:0] lim
    );
        logic [COORD_BITS-1:0] q;
        logic [COORD_BITS+1:0] l;
        logic [COORD_BITS+1:0] sum;
        q   = (p >= COORD_BITS'(GROW_EACH)) ? p - COORD_BITS'(GROW_EACH) : '0;
        l   = (COORD_BITS+2)'(len) + (COORD_BITS+2)'(GROW_BOTH);
        sum = (COORD_BITS+2)'(q) + l;
        if (sum > (COORD_BITS+2)'(lim))
        begin
            l = (lim > q) ? (COORD_BITS+2)'(lim - q) : '0;
        end
        return {l[COORD_BITS-1:0], q};
    endfunction

    // input decode
    assign in_sof     = s_axis_tuser[0];
    assign in_box.x   = s_axis_tdata[X_LO +: COORD_BITS];
    assign in_box.y   = s_axis_tdata[Y_LO +: COORD_BITS];
    assign in_box.w   = s_axis_tdata[W_LO +: COORD_BITS];
    assign in_box.h   = s_axis_tdata[H_LO +: COORD_BITS];
    assign in_score   = s_axis_tdata[SCORE_LO +: SCORE_BITS];
    assign score_pass = (in_score > score_thr_reg);
    assign in_accept  = s_axis_tvalid && s_axis_tready;

    // handshake outputs
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_full_reg;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= SCORE_THR_RST;
            dup_thr_reg   <= DUP_THR_RST;
            frame_w_reg   <= FRAME_W_RST;
            frame_h_reg   <= FRAME_H_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SCORE_THR: score_thr_reg <= cfg_data[SCORE_BITS-1:0];
                CFG_DUP_THR:   dup_thr_reg   <= cfg_data[DUP_BITS-1:0];
                CFG_FRAME_W:   frame_w_reg   <= cfg_data[COORD_BITS-1:0];
                CFG_FRAME_H:   frame_h_reg   <= cfg_data[COORD_BITS-1:0];
            endcase
        end
    end

    // scan control decode
    assign issue     = (state_reg == ST_SCAN) && (scan_idx_reg < kept_count_reg);
    assign scan_done = (state_reg == ST_SCAN) && !issue && !rd_valid_reg && !cmp_valid_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign store_ok  = (kept_count_reg < CNT_BITS'(MAX_KEPT));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && score_pass)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = dup_reg ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready   = (state_reg == ST_IDLE);
        kept_count_next = kept_count_reg;
        scan_idx_next   = scan_idx_reg;
        rd_valid_next   = issue;
        cmp_valid_next  = rd_valid_reg;
        dup_next        = dup_reg;
        m_valid_next    = m_valid_reg;
        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            scan_idx_next = '0;
            dup_next      = 1'b0;
            if (in_sof)
            begin
                kept_count_next = '0;
            end
        end
        if (issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (cmp_valid_reg && hit)
        begin
            dup_next = 1'b1;
        end
        if (emit_fire)
        begin
            m_valid_next = 1'b1;
            if (store_ok)
            begin
                kept_count_next = kept_count_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            kept_count_reg <= '0;
            scan_idx_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            dup_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kept_count_reg <= kept_count_next;
            scan_idx_reg   <= scan_idx_next;
            rd_valid_reg   <= rd_valid_next;
            cmp_valid_reg  <= cmp_valid_next;
            dup_reg        <= dup_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // item capture and area of the new box
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            frame_reg <= s_axis_tdata[FRAME_BITS-1:0];
            score_reg <= in_score;
            box_reg   <= in_box;
        end
        an_reg <= AREA_BITS'(box_reg.w) * AREA_BITS'(box_reg.h);
    end

    // kept-box memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (emit_fire && store_ok)
        begin
            kept_mem[kept_count_reg[IDX_BITS-1:0]] <= box_reg;
        end
        rd_box_reg <= kept_mem[scan_idx_reg[IDX_BITS-1:0]];
    end

    // overlap stage: per-axis overlap, intersection and stored area
    assign ov_x  = overlap_len(box_reg.x, box_reg.w, rd_box_reg.x, rd_box_reg.w);
    assign ov_y  = overlap_len(box_reg.y, box_reg.h, rd_box_reg.y, rd_box_reg.h);
    assign ident = (box_reg == rd_box_reg);

    always_ff @(posedge clk)
    begin
        inter_reg <= INTER_BITS'(ov_x) * INTER_BITS'(ov_y);
        ak_reg    <= AREA_BITS'(rd_box_reg.w) * AREA_BITS'(rd_box_reg.h);
        ident_reg <= ident;
    end

    // ratio stage: intersection * 256 against threshold * smaller area
    assign amin = (an_reg < ak_reg) ? an_reg : ak_reg;
    assign lhs  = {inter_reg, 8'd0};
    assign rhs  = CMP_BITS'(dup_thr_reg) * CMP_BITS'(amin);
    assign hit  = !ident_reg && (lhs > rhs);

    // expanded and clipped output box
    assign gx = grow_clip(box_reg.x, box_reg.w, frame_w_reg);
    assign gy = grow_clip(box_reg.y, box_reg.h, frame_h_reg);

    // result register
    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            m_data_reg <= TDATA_BITS'({score_reg,
                                       gy[2*COORD_BITS-1:COORD_BITS],
                                       gx[2*COORD_BITS-1:COORD_BITS],
                                       gy[COORD_BITS-1:0],
                                       gx[COORD_BITS-1:0],
                                       frame_reg});
            m_full_reg <= !store_ok;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_BITS'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= kept_count_reg))
        else $error("scan index passed kept count");

    a_store_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && store_ok) |=> (kept_count_reg == $past(kept_count_reg) + 1'b1))
        else $error("kept box not counted");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid_reg || cmp_valid_reg) |-> (state_reg == ST_SCAN))
        else $error("compare pipeline busy outside scan");

    a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |-> !dup_reg)
        else $error("duplicate box emitted");

endmodule

/* tb/detection_duplicate_filter_core_tb.sv */
// ----------------------------------------------------------------------------
// detection_duplicate_filter_core_tb
// self-checking bench: boxes streamed in, kept boxes predicted and compared
// field by field on the result stream, with random sender gaps, receiver
// stalls and register settings changed between phases
// ----------------------------------------------------------------------------
module detection_duplicate_filter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ddf_pkg::*;

    // cycles let pass after the last result before touching registers
    localparam int DRAIN_CYCLES = MAX_KEPT + 16;
    localparam int END_LIMIT    = 20000;
    localparam int PRINT_LIMIT  = 50;

    // one detection request
    typedef struct {
        bit                     sof;
        logic [FRAME_BITS-1:0]  frame;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COORD_BITS-1:0]  w;
        logic [COORD_BITS-1:0]  h;
        logic signed [SCORE_BITS-1:0] score;
    } det_t;

    // one emitted box
    typedef struct {
        logic [FRAME_BITS-1:0]  frame;
        logic [COORD_BITS-1:0]  x;
        logic [COORD_BITS-1:0]  y;
        logic [COORD_BITS-1:0]  w;
        logic [COORD_BITS-1:0]  h;
        logic [SCORE_BITS-1:0]  score;
        bit                     full;
    } emit_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // frame_number, box_x, box_y, box_w, box_h, box_score (lowest bit up)
    logic [TDATA_BITS-1:0]      s_axis_tdata = '0;
    // start_of_frame
    logic [0:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // out_frame_number, out_x, out_y, out_w, out_h, out_score (lowest bit up)
    logic [TDATA_BITS-1:0]      m_axis_tdata;
    // store_full
    logic [0:0]                 m_axis_tuser;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

    // predictor state: kept boxes and register mirror
    box_t                       kept_store [MAX_KEPT];
    int unsigned                kept_n = 0;
    logic signed [SCORE_BITS-1:0] thr_score = SCORE_THR_RST;
    logic [DUP_BITS-1:0]        thr_dup = DUP_THR_RST;
    logic [COORD_BITS-1:0]      lim_w = FRAME_W_RST;
    logic [COORD_BITS-1:0]      lim_h = FRAME_H_RST;

    emit_t                      predicted_emits [$];
    int                         err_count = 0;
    int                         burst_left = 0;
    int                         rx_mode = 0;
    int                         rx_left = 0;
    int                         rx_hold = 0;

    detection_duplicate_filter_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #4 clk = ~clk;

    // mismatch report, printing capped
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // overlap length of two spans, 0 when disjoint
    function automatic longint unsigned span_overlap(input int unsigned a0,
        input int unsigned al, input int unsigned b0, input int unsigned bl);
        int unsigned lo;
        int unsigned hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
        return (hi > lo) ? longint'(hi - lo) : 64'd0;
    endfunction

    // grow a span on both sides, clamp the start at 0, clip length to the frame
    function automatic void grow_span(input int p, input int len, input int lim,
        output logic [COORD_BITS-1:0] op, output logic [COORD_BITS-1:0] olen);
        int q;
        int l;
        q = p - GROW_EACH;
        l = len + GROW_BOTH;
        if (q < 0)
            q = 0;
        if (q + l > lim)
            l = lim - q;
        if (l < 0)
            l = 0;
        op = q[COORD_BITS-1:0];
        olen = l[COORD_BITS-1:0];
    endfunction

    // greedy suppression predictor: updates the kept store, queues the emit
    task automatic predict_filter(input det_t d);
        box_t            b;
        box_t            k;
        bit              dup;
        longint unsigned an;
        longint unsigned ak;
        longint unsigned amin;
        longint unsigned inter;
        emit_t           r;
        if (d.sof)
            kept_n = 0;
        b.x = d.x;
        b.y = d.y;
        b.w = d.w;
        b.h = d.h;
        if (!(d.score > thr_score))
            return;
        an = 64'(b.w) * 64'(b.h);
        dup = 1'b0;
        for (int i = 0; i < kept_n && !dup; i++)
        begin
            k = kept_store[i];
            // an identical box never counts as a match
            if (k == b)
                continue;
            ak = 64'(k.w) * 64'(k.h);
            amin = (an < ak) ? an : ak;
            inter = span_overlap(b.x, b.w, k.x, k.w) * span_overlap(b.y, b.h, k.y, k.h);
            if (inter * 256 > 64'(thr_dup) * amin)
                dup = 1'b1;
        end
        if (dup)
            return;
        r.full = 1'b0;
        if (kept_n < MAX_KEPT)
        begin
            kept_store[kept_n] = b;
            kept_n++;
        end
        else
            r.full = 1'b1;
        grow_span(int'(b.x), int'(b.w), int'(lim_w), r.x, r.w);
        grow_span(int'(b.y), int'(b.h), int'(lim_h), r.y, r.h);
        r.frame = d.frame;
        r.score = d.score;
        predicted_emits = {predicted_emits, r};
    endtask

    function automatic det_t mk_det(input bit sof, input int frame, input int x,
        input int y, input int w, input int h, input int score);
        det_t d;
        d.sof = sof;
        d.frame = frame[FRAME_BITS-1:0];
        d.x = x[COORD_BITS-1:0];
        d.y = y[COORD_BITS-1:0];
        d.w = w[COORD_BITS-1:0];
        d.h = h[COORD_BITS-1:0];
        d.score = score[SCORE_BITS-1:0];
        return d;
    endfunction

    // send one request; bursts of random length with random gaps between
    task automatic send_det(input det_t d);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tdata <= {d.score, d.h, d.w, d.y, d.x, d.frame};
        s_axis_tuser <= d.sof;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_filter(d);
        burst_left--;
    endtask

    task automatic input_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        input_idle();
        while (predicted_emits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SCORE_THR: thr_score = val[SCORE_BITS-1:0];
            CFG_DUP_THR:   thr_dup = val[DUP_BITS-1:0];
            CFG_FRAME_W:   lim_w = val[COORD_BITS-1:0];
            CFG_FRAME_H:   lim_h = val[COORD_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int thr, input int dup, input int fw, input int fh);
        write_reg(CFG_SCORE_THR, thr);
        write_reg(CFG_DUP_THR, dup);
        write_reg(CFG_FRAME_W, fw);
        write_reg(CFG_FRAME_H, fh);
    endtask

    // score threshold at reset defaults: strict test and score extremes
    task automatic test_score_threshold();
        send_det(mk_det(1, 0, 100, 100, 50, 50, 1));
        send_det(mk_det(0, 0, 300, 300, 50, 50, 0));
        send_det(mk_det(0, 0, 300, 300, 50, 50, -32768));
        send_det(mk_det(0, 65535, 300, 300, 50, 50, 32767));
    endtask

    // identical box, heavy overlap, light overlap, zero area, touching edges
    task automatic test_overlap_cases();
        send_det(mk_det(0, 1, 100, 100, 50, 50, 5));
        send_det(mk_det(0, 1, 110, 110, 50, 50, 5));
        send_det(mk_det(0, 1, 140, 140, 50, 50, 5));
        send_det(mk_det(0, 1, 120, 120, 0, 30, 5));
        send_det(mk_det(0, 1, 150, 100, 50, 50, 5));
    endtask

    // corner clamp and size clip, including clip below zero
    task automatic test_frame_clip();
        send_det(mk_det(1, 2, 0, 0, 4095, 4095, 1));
        send_det(mk_det(1, 3, 4095, 4095, 4095, 4095, 1));
        send_det(mk_det(1, 4, 10, 10, 5, 5, 1));
    endtask

    // register extremes: reject all, keep nearly all, dup 0, 256 and 511, frame 0
    task automatic test_register_extremes();
        set_config(32767, 0, 1, 1);
        send_det(mk_det(1, 5, 500, 500, 100, 100, 32767));
        set_config(-32768, 0, 4095, 4095);
        send_det(mk_det(1, 6, 500, 500, 100, 100, -32767));
        send_det(mk_det(0, 6, 500, 500, 100, 100, -32768));
        send_det(mk_det(0, 6, 550, 550, 100, 100, 100));
        send_det(mk_det(0, 6, 600, 600, 100, 100, 100));
        set_config(0, 256, 0, 0);
        send_det(mk_det(1, 7, 200, 200, 100, 100, 1));
        send_det(mk_det(0, 7, 210, 210, 100, 100, 1));
        set_config(0, 511, 4095, 1);
        send_det(mk_det(0, 7, 215, 215, 100, 100, 1));
    endtask

    // disjoint boxes past the store depth, then a duplicate of a stored box
    task automatic test_store_full();
        for (int k = 0; k < MAX_KEPT + 6; k++)
            send_det(mk_det(k == 0, 8, (k % 8) * 200, (k / 8) * 120, 50, 50, 100));
        send_det(mk_det(0, 8, 10, 10, 50, 50, 100));
    endtask

    // score near the threshold, sometimes fully random
    function automatic int pick_score();
        int s;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            s = int'(thr_score) + $urandom_range(1, 3000);
        else if (pick < 85)
            s = int'(thr_score);
        else
            s = int'($urandom_range(0, 65535)) - 32768;
        if (s > 32767)
            s = 32767;
        return s;
    endfunction

    // random frames: clustered boxes, repeats, fill frames and noise
    task automatic test_random_frames(input int n_items);
        int sent;
        int phase;
        int n_boxes;
        int cx [3];
        int cy [3];
        int c;
        int frame;
        bit fill;
        det_t d;
        det_t last;
        sent = 0;
        phase = 0;
        last = mk_det(0, 0, 0, 0, 10, 10, 0);
        while (sent < n_items)
        begin
            // new register setting per phase, extremes mixed in
            case ($urandom_range(0, 3))
                0: write_reg(CFG_SCORE_THR, int'($urandom_range(0, 1024)) - 512);
                1: write_reg(CFG_SCORE_THR, int'($urandom_range(0, 65535)));
                2: write_reg(CFG_SCORE_THR, -32768);
                default: write_reg(CFG_SCORE_THR, 0);
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(CFG_DUP_THR, 0);
                1: write_reg(CFG_DUP_THR, 256);
                2: write_reg(CFG_DUP_THR, 511);
                default: write_reg(CFG_DUP_THR, $urandom_range(0, 256));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FRAME_W, 4095);
                1: write_reg(CFG_FRAME_W, 1);
                2: write_reg(CFG_FRAME_W, 1920);
                default: write_reg(CFG_FRAME_W, $urandom_range(1, 4095));
            endcase
            case ($urandom_range(0, 3))
                0: write_reg(CFG_FRAME_H, 4095);
                1: write_reg(CFG_FRAME_H, 1);
                2: write_reg(CFG_FRAME_H, 1080);
                default: write_reg(CFG_FRAME_H, $urandom_range(1, 4095));
            endcase
            for (int f = 0; f < 8 && sent < n_items; f++)
            begin
                frame = $urandom_range(0, 65535);
                fill = ($urandom_range(0, 9) == 0);
                n_boxes = fill ? $urandom_range(66, 72) : $urandom_range(1, 20);
                for (int j = 0; j < 3; j++)
                begin
                    cx[j] = $urandom_range(0, 3000);
                    cy[j] = $urandom_range(0, 3000);
                end
                for (int k = 0; k < n_boxes; k++)
                begin
                    if (fill)
                    begin
                        // disjoint grid, or the same box again, so the store fills
                        if ($urandom_range(0, 3) == 0 && k > 0)
                            d = mk_det(0, frame, last.x, last.y, last.w, last.h,
                                       pick_score());
                        else
                            d = mk_det(0, frame, (k % 9) * 450, (k / 9) * 450,
                                       $urandom_range(0, 400), $urandom_range(0, 400),
                                       pick_score());
                    end
                    else if ($urandom_range(0, 99) < 12)
                        d = mk_det($urandom_range(0, 1), $urandom_range(0, 65535),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   int'($urandom_range(0, 65535)));
                    else if ($urandom_range(0, 9) == 0 && k > 0)
                        d = mk_det(0, frame, last.x, last.y, last.w, last.h, pick_score());
                    else
                    begin
                        c = $urandom_range(0, 2);
                        d = mk_det(0, frame, cx[c] + $urandom_range(0, 60),
                                   cy[c] + $urandom_range(0, 60),
                                   $urandom_range(20, 200), $urandom_range(20, 200),
                                   pick_score());
                    end
                    // start of frame, sometimes missing or repeated mid-frame
                    if (k == 0)
                        d.sof = ($urandom_range(0, 19) != 0);
                    else if ($urandom_range(0, 24) == 0)
                        d.sof = 1'b1;
                    send_det(d);
                    last = d;
                    sent++;
                end
            end
            phase++;
        end
    endtask

    // receiver stall pattern: modes of free flow, random, periodic, long holds
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end
        else
            rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 99) < 60);
            2: m_axis_tready <= (rx_left % 3 == 0);
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        rx_hold = $urandom_range(1, 24);
                end
            end
        endcase
    end

    // result checker against the oldest prediction
    always @(posedge clk)
    begin
        emit_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (predicted_emits.size() == 0)
                report_mismatch($sformatf("unexpected result 0x%0h", m_axis_tdata));
            else
            begin
                want = predicted_emits.pop_front();
                check_field("out_frame_number", m_axis_tdata[15:0], want.frame);
                check_field("out_x", m_axis_tdata[27:16], want.x);
                check_field("out_y", m_axis_tdata[39:28], want.y);
                check_field("out_w", m_axis_tdata[51:40], want.w);
                check_field("out_h", m_axis_tdata[63:52], want.h);
                check_field("out_score", m_axis_tdata[79:64], want.score);
                check_field("store_full", m_axis_tuser[0], want.full);
            end
        end
    end

    // run limit
    initial
    begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // test sequence
    initial
    begin
        int waited;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_score_threshold();
        test_overlap_cases();
        test_frame_clip();
        test_register_extremes();
        set_config(0, 128, 1920, 1080);
        test_store_full();
        test_random_frames(830);
        input_idle();
        waited = 0;
        while (predicted_emits.size() != 0 && waited < END_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_emits.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", predicted_emits.size()));
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ddf_pkg.sv
rtl/detection_duplicate_filter_core.sv
tb/detection_duplicate_filter_core_tb.sv
